/* design/rain_flag_threshold_sweep_tally_core_assert.svh */
// Assertion macros shared by the tally core.
`ifndef RAIN_FLAG_THRESHOLD_SWEEP_TALLY_CORE_ASSERT_SVH
`define RAIN_FLAG_THRESHOLD_SWEEP_TALLY_CORE_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define RFTS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define RFTS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/rfts_pkg.sv */
// Shared constants, types and helper functions of the rain-flag tally core.
package rfts_pkg;

    localparam int NUM_THRESH   = 100;
    localparam int COUNT_WIDTH  = 32;
    localparam int HIST_SIZE    = 6 * NUM_THRESH;
    localparam int CLASS_SPAN   = 2 * NUM_THRESH;
    localparam int ADDR_W       = $clog2(HIST_SIZE);
    localparam int T_W          = $clog2(NUM_THRESH + 1);

    localparam int FLAG_FULL    = 1000000;
    localparam int FLAG_W       = $clog2(FLAG_FULL + 1);
    localparam int THRESH_STEP  = 1000;
    localparam int OFFSET_CENTER = 180;
    localparam int RAIN_LIMIT   = 1000;

    localparam int READ_IDX_W   = 10;
    localparam int IDX_TOTAL    = HIST_SIZE;
    localparam int IDX_CLASSIFIED = HIST_SIZE + 1;
    localparam int IDX_UNCLS0   = HIST_SIZE + 2;

    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MINUTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RAIN_THRESH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MISSING_SPEED = 2'd2;
    localparam logic [7:0]  MAX_MINUTES_RST   = 8'd30;
    localparam logic [15:0] RAIN_THRESH_RST   = 16'd20;
    localparam logic [15:0] MISSING_SPEED_RST = 16'd32767;

    localparam logic CMD_SAMPLE = 1'b0;
    localparam logic CMD_READ   = 1'b1;

    localparam logic [1:0] STAT_SKIP  = 2'd0;
    localparam logic [1:0] STAT_UNCLS = 2'd1;
    localparam logic [1:0] STAT_CLS   = 2'd2;

    localparam logic [1:0] CLS_FREE = 2'd0;
    localparam logic [1:0] CLS_RAIN = 2'd1;
    localparam logic [1:0] CLS_MID  = 2'd2;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SWEEP,
        ST_DRAIN,
        ST_READ
    } state_t;

    typedef struct packed {
        logic              keep;
        logic              classifiable;
        logic [1:0]        cls;
        logic [FLAG_W-1:0] flag_mag;
    } sample_info_t;

    // Saturating increment of one counter.
    function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] v);
        return (&v) ? v : v + COUNT_WIDTH'(1);
    endfunction

    // Counter value as seen on the 32-bit read port.
    function automatic logic [31:0] sat32(input logic [COUNT_WIDTH-1:0] v);
        logic [31:0] res;
        if ((COUNT_WIDTH > 32) && (64'(v) > 64'hFFFF_FFFF))
            res = '1;
        else
            res = 32'(v);
        return res;
    endfunction

endpackage

/* design/rfts_hist_ram.sv */
// Simple dual-port histogram memory with a registered read port.
module rfts_hist_ram #(
    parameter int DEPTH  = 600,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

/* design/rfts_classify.sv */
// Sample screening: window, missing wind and rain limit checks, rain class and flag range.
module rfts_classify (
    input  logic [7:0]                  time_difference,
    input  logic [15:0]                 rain_integrated,
    input  logic [15:0]                 wind_speed,
    input  logic signed [23:0]          flag_value_micro,
    input  logic [7:0]                  max_minutes,
    input  logic [15:0]                 rain_threshold_tenths,
    input  logic [15:0]                 missing_speed_marker,
    output rfts_pkg::sample_info_t      info
);

    localparam logic [7:0] CENTER_CODE = 8'(rfts_pkg::OFFSET_CENTER / 2);

    logic [8:0] twice_code;
    logic [8:0] offset_abs;

    assign twice_code = {time_difference, 1'b0};

    always_comb
    begin
        // Magnitude of the offset 2*code - 180, formed without a signed subtract.
        if (time_difference >= CENTER_CODE)
            offset_abs = twice_code - 9'(rfts_pkg::OFFSET_CENTER);
        else
            offset_abs = 9'(rfts_pkg::OFFSET_CENTER) - twice_code;

        info.keep = (offset_abs <= {1'b0, max_minutes})
                 && (wind_speed != missing_speed_marker)
                 && (rain_integrated < 16'(rfts_pkg::RAIN_LIMIT));

        if (rain_integrated == 16'd0)
            info.cls = rfts_pkg::CLS_FREE;
        else if (rain_integrated > rain_threshold_tenths)
            info.cls = rfts_pkg::CLS_RAIN;
        else
            info.cls = rfts_pkg::CLS_MID;

        info.classifiable = !flag_value_micro[23]
                         && (flag_value_micro[22:0] <= 23'(rfts_pkg::FLAG_FULL));
        info.flag_mag = rfts_pkg::FLAG_W'(flag_value_micro[22:0]);
    end

endmodule

/* design/rain_flag_threshold_sweep_tally_core.sv */
// Rain-flag threshold sweep tally core: control, counters and histogram sweep.
//
//  channel   | handshake           | payload
//  ----------+---------------------+---------------------------------------------------
//  command   | start / busy        | command, time_difference, rain_integrated,
//            |                     | wind_speed, flag_value_micro, read_index
//  result    | done (one cycle)    | read_count, sample_status, rain_class
//  config    | cfg_we              | cfg_index, cfg_data
//
// A skipped or unclassified sample gives its result in the cycle after the transaction
// and busy stays low, so such samples can follow every cycle. A read passes through
// the READ state with busy high. A classified sample sweeps all NUM_THRESH thresholds
// with busy high: one read-modify-write per threshold through the single write port
// of the histogram memory. After reset the memory is cleared one entry a cycle
// (HIST_SIZE = 600 entries) with busy high. Results cannot be stalled by the receiver.
module rain_flag_threshold_sweep_tally_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                command,
    input  logic [7:0]          time_difference,
    input  logic [15:0]         rain_integrated,
    input  logic [15:0]         wind_speed,
    input  logic signed [23:0]  flag_value_micro,
    input  logic [9:0]          read_index,
    output logic                done,
    output logic [31:0]         read_count,
    output logic [1:0]          sample_status,
    output logic [1:0]          rain_class,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);

    localparam int ADDR_W = rfts_pkg::ADDR_W;
    localparam int T_W    = rfts_pkg::T_W;
    localparam int CW     = rfts_pkg::COUNT_WIDTH;
    localparam int FW     = rfts_pkg::FLAG_W;

    rfts_pkg::state_t       state_reg, state_next;
    rfts_pkg::sample_info_t info;

    logic [7:0]        max_minutes_reg;
    logic [15:0]       rain_thresh_reg;
    logic [15:0]       missing_speed_reg;

    logic [CW-1:0]     total_reg;
    logic [CW-1:0]     classified_reg;
    logic [CW-1:0]     uncls_reg [3];

    logic [ADDR_W-1:0] ptr_reg;
    logic [T_W-1:0]    t_reg;
    logic [FW-1:0]     thr_reg;
    logic [FW-1:0]     flag_mag_reg;
    logic [1:0]        cls_reg;
    logic              wr_pend_reg;
    logic [ADDR_W-1:0] wr_addr_reg;
    logic              hist_sel_reg;
    logic [31:0]       rd_small_reg;

    logic              done_reg;
    logic [31:0]       read_count_reg;
    logic [1:0]        status_reg;
    logic [1:0]        class_reg;

    logic              accept;
    logic              is_read;
    logic              go_sweep;
    logic              above;
    logic [ADDR_W-1:0] sweep_addr;
    logic [ADDR_W-1:0] class_base;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CW-1:0]     wr_data;
    logic [CW-1:0]     rd_data;
    logic [31:0]       idx_ext;
    logic              idx_in_hist;
    logic [31:0]       small_val;

    rfts_classify u_classify (
        .time_difference       (time_difference),
        .rain_integrated       (rain_integrated),
        .wind_speed            (wind_speed),
        .flag_value_micro      (flag_value_micro),
        .max_minutes           (max_minutes_reg),
        .rain_threshold_tenths (rain_thresh_reg),
        .missing_speed_marker  (missing_speed_reg),
        .info                  (info)
    );

    rfts_hist_ram #(
        .DEPTH  (rfts_pkg::HIST_SIZE),
        .WIDTH  (CW),
        .ADDR_W (ADDR_W)
    ) u_hist_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign busy     = (state_reg != rfts_pkg::ST_IDLE);
    assign accept   = start && !busy;
    assign is_read  = (command == rfts_pkg::CMD_READ);
    assign go_sweep = !is_read && info.keep && info.classifiable;

    // Class bases are even, so the above-threshold bit is the address LSB.
    assign above      = (flag_mag_reg > thr_reg);
    assign sweep_addr = {ptr_reg[ADDR_W-1:1], above};
    assign rd_addr    = (state_reg == rfts_pkg::ST_SWEEP) ? sweep_addr
                                                          : ADDR_W'(read_index);

    always_comb
    begin
        case (info.cls)
            rfts_pkg::CLS_RAIN: class_base = ADDR_W'(rfts_pkg::CLASS_SPAN);
            rfts_pkg::CLS_MID:  class_base = ADDR_W'(2 * rfts_pkg::CLASS_SPAN);
            default:            class_base = '0;
        endcase
    end

    always_comb
    begin
        if (state_reg == rfts_pkg::ST_CLEAR)
        begin
            wr_en   = 1'b1;
            wr_addr = ptr_reg;
            wr_data = '0;
        end
        else
        begin
            wr_en   = wr_pend_reg;
            wr_addr = wr_addr_reg;
            wr_data = rfts_pkg::sat_inc(rd_data);
        end
    end

    // Counters kept in flip-flops are picked at the transaction; histogram entries
    // come from the registered memory read in the cycle after.
    assign idx_ext     = 32'(read_index);
    assign idx_in_hist = (idx_ext < 32'(rfts_pkg::HIST_SIZE));

    always_comb
    begin
        if (idx_ext == 32'(rfts_pkg::IDX_TOTAL))
            small_val = rfts_pkg::sat32(total_reg);
        else if (idx_ext == 32'(rfts_pkg::IDX_CLASSIFIED))
            small_val = rfts_pkg::sat32(classified_reg);
        else if (idx_ext == 32'(rfts_pkg::IDX_UNCLS0))
            small_val = rfts_pkg::sat32(uncls_reg[0]);
        else if (idx_ext == 32'(rfts_pkg::IDX_UNCLS0 + 1))
            small_val = rfts_pkg::sat32(uncls_reg[1]);
        else if (idx_ext == 32'(rfts_pkg::IDX_UNCLS0 + 2))
            small_val = rfts_pkg::sat32(uncls_reg[2]);
        else
            small_val = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= rfts_pkg::ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            rfts_pkg::ST_CLEAR:
            begin
                if (ptr_reg == ADDR_W'(rfts_pkg::HIST_SIZE - 1))
                    state_next = rfts_pkg::ST_IDLE;
            end
            rfts_pkg::ST_IDLE:
            begin
                if (accept && is_read)
                    state_next = rfts_pkg::ST_READ;
                else if (accept && go_sweep)
                    state_next = rfts_pkg::ST_SWEEP;
            end
            rfts_pkg::ST_SWEEP:
            begin
                if (t_reg == T_W'(rfts_pkg::NUM_THRESH - 1))
                    state_next = rfts_pkg::ST_DRAIN;
            end
            rfts_pkg::ST_DRAIN: state_next = rfts_pkg::ST_IDLE;
            rfts_pkg::ST_READ:  state_next = rfts_pkg::ST_IDLE;
            default:            state_next = rfts_pkg::ST_IDLE;
        endcase
    end

    // Control state, counters and configuration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_minutes_reg   <= rfts_pkg::MAX_MINUTES_RST;
            rain_thresh_reg   <= rfts_pkg::RAIN_THRESH_RST;
            missing_speed_reg <= rfts_pkg::MISSING_SPEED_RST;
            total_reg         <= '0;
            classified_reg    <= '0;
            uncls_reg[0]      <= '0;
            uncls_reg[1]      <= '0;
            uncls_reg[2]      <= '0;
            ptr_reg           <= '0;
            t_reg             <= '0;
            wr_pend_reg       <= 1'b0;
            done_reg          <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    rfts_pkg::CFG_MAX_MINUTES:   max_minutes_reg   <= cfg_data[7:0];
                    rfts_pkg::CFG_RAIN_THRESH:   rain_thresh_reg   <= cfg_data;
                    rfts_pkg::CFG_MISSING_SPEED: missing_speed_reg <= cfg_data;
                    default: ;
                endcase
            end

            done_reg    <= 1'b0;
            wr_pend_reg <= (state_reg == rfts_pkg::ST_SWEEP);

            case (state_reg)
                rfts_pkg::ST_CLEAR:
                begin
                    ptr_reg <= ptr_reg + ADDR_W'(1);
                end
                rfts_pkg::ST_IDLE:
                begin
                    if (accept && !is_read && info.keep)
                    begin
                        total_reg <= rfts_pkg::sat_inc(total_reg);
                        if (info.classifiable)
                            classified_reg <= rfts_pkg::sat_inc(classified_reg);
                        else
                        begin
                            for (int i = 0; i < 3; i++)
                            begin
                                if (info.cls == 2'(i))
                                    uncls_reg[i] <= rfts_pkg::sat_inc(uncls_reg[i]);
                            end
                        end
                    end
                    if (accept && go_sweep)
                    begin
                        ptr_reg <= class_base;
                        t_reg   <= '0;
                    end
                    else if (accept && !is_read)
                    begin
                        done_reg <= 1'b1;
                    end
                end
                rfts_pkg::ST_SWEEP:
                begin
                    ptr_reg <= ptr_reg + ADDR_W'(2);
                    t_reg   <= t_reg + T_W'(1);
                end
                rfts_pkg::ST_DRAIN:
                begin
                    done_reg <= 1'b1;
                end
                rfts_pkg::ST_READ:
                begin
                    done_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Sweep payload and result registers.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            rfts_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    thr_reg      <= '0;
                    flag_mag_reg <= info.flag_mag;
                    cls_reg      <= info.cls;
                    hist_sel_reg <= idx_in_hist;
                    rd_small_reg <= small_val;
                    if (!is_read)
                    begin
                        read_count_reg <= '0;
                        if (!info.keep)
                        begin
                            status_reg <= rfts_pkg::STAT_SKIP;
                            class_reg  <= rfts_pkg::CLS_FREE;
                        end
                        else
                        begin
                            status_reg <= rfts_pkg::STAT_UNCLS;
                            class_reg  <= info.cls;
                        end
                    end
                end
            end
            rfts_pkg::ST_SWEEP:
            begin
                thr_reg     <= thr_reg + FW'(rfts_pkg::THRESH_STEP);
                wr_addr_reg <= sweep_addr;
            end
            rfts_pkg::ST_DRAIN:
            begin
                read_count_reg <= '0;
                status_reg     <= rfts_pkg::STAT_CLS;
                class_reg      <= cls_reg;
            end
            rfts_pkg::ST_READ:
            begin
                read_count_reg <= hist_sel_reg ? rfts_pkg::sat32(rd_data) : rd_small_reg;
                status_reg     <= rfts_pkg::STAT_SKIP;
                class_reg      <= rfts_pkg::CLS_FREE;
            end
            default: ;
        endcase
    end

    assign done          = done_reg;
    assign read_count    = read_count_reg;
    assign sample_status = status_reg;
    assign rain_class    = class_reg;

`include "rain_flag_threshold_sweep_tally_core_assert.svh"

    `RFTS_ASSERT_SAME(a_write_only_when_working, wr_en, (state_reg == rfts_pkg::ST_CLEAR) || (state_reg == rfts_pkg::ST_SWEEP) || (state_reg == rfts_pkg::ST_DRAIN), "histogram written outside clear or sweep")
    `RFTS_ASSERT_NEXT(a_classified_enters_sweep, accept && go_sweep, state_reg == rfts_pkg::ST_SWEEP, "classified sample did not start a sweep")
    `RFTS_ASSERT_SAME(a_no_result_in_sweep, state_reg == rfts_pkg::ST_SWEEP, !done_reg, "result strobe during a sweep")
    `RFTS_ASSERT_NEXT(a_drain_gives_result, state_reg == rfts_pkg::ST_DRAIN, done_reg && (status_reg == rfts_pkg::STAT_CLS), "sweep ended without a classified result")

endmodule

/* tb/sv/rfts_tb_pkg.sv */
// Transaction types and the tally scoreboard used by the tally core testbench.
`timescale 1ns / 100ps
package rfts_tb_pkg;

    import rfts_pkg::*;

    typedef struct packed {
        logic        command;
        logic [7:0]  time_difference;
        logic [15:0] rain_integrated;
        logic [15:0] wind_speed;
        logic [23:0] flag_value_micro;
        logic [9:0]  read_index;
    } cell_item_t;

    typedef struct packed {
        logic [31:0] read_count;
        logic [1:0]  sample_status;
        logic [1:0]  rain_class;
    } tally_result_t;

    class tally_scoreboard;

        logic [COUNT_WIDTH-1:0] hist_cnt [HIST_SIZE];
        logic [COUNT_WIDTH-1:0] total_cnt;
        logic [COUNT_WIDTH-1:0] classified_cnt;
        logic [COUNT_WIDTH-1:0] uncls_cnt [3];

        logic [7:0]  max_minutes;
        logic [15:0] rain_thresh;
        logic [15:0] missing_speed;

        tally_result_t pending_outcomes [$];
        int unsigned   error_count;

        function new();
            foreach (hist_cnt[i])
                hist_cnt[i] = '0;
            foreach (uncls_cnt[i])
                uncls_cnt[i] = '0;
            total_cnt      = '0;
            classified_cnt = '0;
            max_minutes    = MAX_MINUTES_RST;
            rain_thresh    = RAIN_THRESH_RST;
            missing_speed  = MISSING_SPEED_RST;
            error_count    = 0;
        endfunction

        function logic [COUNT_WIDTH-1:0] bumped(input logic [COUNT_WIDTH-1:0] v);
            return (v == {COUNT_WIDTH{1'b1}}) ? v : v + 1'b1;
        endfunction

        function void write_reg(input logic [1:0] idx, input logic [15:0] data);
            case (idx)
                CFG_MAX_MINUTES:   max_minutes   = data[7:0];
                CFG_RAIN_THRESH:   rain_thresh   = data;
                CFG_MISSING_SPEED: missing_speed = data;
                default: ;
            endcase
        endfunction

        // Queues the outcome of one accepted transaction; a sample also updates counters.
        function void note_cell(input cell_item_t it);
            tally_result_t          r;
            logic [COUNT_WIDTH-1:0] v;
            int                     offset;
            int                     flag;
            int                     idx;
            int                     above;
            logic [1:0]             cls;
            r = '0;
            if (it.command == CMD_READ) begin
                idx = int'(it.read_index);
                if (idx < HIST_SIZE)
                    v = hist_cnt[idx];
                else if (idx == IDX_TOTAL)
                    v = total_cnt;
                else if (idx == IDX_CLASSIFIED)
                    v = classified_cnt;
                else if (idx >= IDX_UNCLS0 && idx <= IDX_UNCLS0 + 2)
                    v = uncls_cnt[idx - IDX_UNCLS0];
                else
                    v = '0;
                r.read_count = (64'(v) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(v);
            end else begin
                offset = 2 * int'(it.time_difference) - OFFSET_CENTER;
                if (offset < 0)
                    offset = -offset;
                if (offset <= int'(max_minutes) && it.wind_speed != missing_speed &&
                    int'(it.rain_integrated) < RAIN_LIMIT) begin
                    total_cnt = bumped(total_cnt);
                    if (it.rain_integrated == 16'd0)
                        cls = CLS_FREE;
                    else if (it.rain_integrated > rain_thresh)
                        cls = CLS_RAIN;
                    else
                        cls = CLS_MID;
                    r.rain_class = cls;
                    flag = int'($signed(it.flag_value_micro));
                    if (flag < 0 || flag > FLAG_FULL) begin
                        uncls_cnt[cls] = bumped(uncls_cnt[cls]);
                        r.sample_status = STAT_UNCLS;
                    end else begin
                        classified_cnt = bumped(classified_cnt);
                        for (int t = 0; t < NUM_THRESH; t++) begin
                            above = (flag > t * THRESH_STEP) ? 1 : 0;
                            idx = int'(cls) * CLASS_SPAN + t * 2 + above;
                            hist_cnt[idx] = bumped(hist_cnt[idx]);
                        end
                        r.sample_status = STAT_CLS;
                    end
                end
            end
            pending_outcomes.push_back(r);
        endfunction

        function void check_result(input logic [31:0] count, input logic [1:0] status,
                                   input logic [1:0] cls);
            tally_result_t exp_r;
            if (pending_outcomes.size() == 0) begin
                $display("%0t: result with no transaction pending: count %0d status %0d class %0d",
                         $time, count, status, cls);
                error_count++;
                return;
            end
            exp_r = pending_outcomes.pop_front();
            if (count !== exp_r.read_count) begin
                $display("%0t: read_count expected %0d, got %0d", $time, exp_r.read_count, count);
                error_count++;
            end
            if (status !== exp_r.sample_status) begin
                $display("%0t: sample_status expected %0d, got %0d", $time,
                         exp_r.sample_status, status);
                error_count++;
            end
            if (cls !== exp_r.rain_class) begin
                $display("%0t: rain_class expected %0d, got %0d", $time, exp_r.rain_class, cls);
                error_count++;
            end
        endfunction

    endclass

endpackage

/* tb/sv/tb_rain_flag_threshold_sweep_tally_core.sv */
// Top-level testbench of the rain-flag threshold sweep tally core.
`timescale 1ns / 100ps
module tb_rain_flag_threshold_sweep_tally_core;

    import rfts_pkg::*;
    import rfts_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 300000;
    localparam int PHASE_ITEMS  = 100;
    localparam int DRAIN_CYCLES = NUM_THRESH + 10;
    localparam logic [1:0] CFG_SPARE = 2'd3;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic               command;
    logic [7:0]         time_difference;
    logic [15:0]        rain_integrated;
    logic [15:0]        wind_speed;
    logic signed [23:0] flag_value_micro;
    logic [9:0]         read_index;
    logic               done;
    logic [31:0]        read_count;
    logic [1:0]         sample_status;
    logic [1:0]         rain_class;
    logic               cfg_we;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    tally_scoreboard sb;
    int unsigned     cycle_count = 0;

    rain_flag_threshold_sweep_tally_core u_top (.*);

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("[rain_flag_threshold_sweep_tally_core] ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_result(read_count, sample_status, rain_class);
    end

    function automatic cell_item_t make_item(input logic cmd, input int td, input int rain,
                                             input int speed, input int flag, input int idx);
        cell_item_t c;
        c.command          = cmd;
        c.time_difference  = 8'(td);
        c.rain_integrated  = 16'(rain);
        c.wind_speed       = 16'(speed);
        c.flag_value_micro = 24'(flag);
        c.read_index       = 10'(idx);
        return c;
    endfunction

    // Mostly samples that pass the window so the histogram sweep is exercised.
    function automatic cell_item_t random_cell();
        cell_item_t c;
        int         pick;
        int         lo;
        int         hi;
        int         rain;
        int         thr;
        c.command          = CMD_SAMPLE;
        c.time_difference  = 8'($urandom);
        c.rain_integrated  = 16'($urandom);
        c.wind_speed       = 16'($urandom);
        c.flag_value_micro = 24'($urandom);
        c.read_index       = 10'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 25)
        begin
            c.command = CMD_READ;
            if ($urandom_range(0, 9) == 0)
                c.read_index = 10'($urandom_range(IDX_UNCLS0 + 3, 1023));
            else
                c.read_index = 10'($urandom_range(0, IDX_UNCLS0 + 2));
        end
        else if (pick >= 37)
        begin
            lo = (OFFSET_CENTER - int'(sb.max_minutes) + 1) / 2;
            hi = (OFFSET_CENTER + int'(sb.max_minutes)) / 2;
            if (lo < 0)
                lo = 0;
            if (hi > 255)
                hi = 255;
            c.time_difference = 8'($urandom_range(hi, lo));
            thr = int'(sb.rain_thresh);
            case ($urandom_range(0, 3))
                0: rain = 0;
                1: rain = (thr < RAIN_LIMIT - 1) ? thr + $urandom_range(0, 2) - 1 : 999;
                default: rain = $urandom_range(1, RAIN_LIMIT - 1);
            endcase
            if (rain < 0)
                rain = 0;
            c.rain_integrated = 16'(rain);
            if (c.wind_speed == sb.missing_speed)
                c.wind_speed = c.wind_speed + 16'd1;
            case ($urandom_range(0, 9))
                6: c.flag_value_micro = 24'($urandom_range(0, 100) * THRESH_STEP
                                            + $urandom_range(0, 2) - 1);
                7: c.flag_value_micro = 24'($urandom_range(0, FLAG_FULL));
                8: c.flag_value_micro = 24'(-int'($urandom_range(1, 8388608)));
                9: c.flag_value_micro = 24'($urandom_range(FLAG_FULL + 1, 8388607));
                default: c.flag_value_micro = 24'($urandom_range(0, 100000));
            endcase
        end
        return c;
    endfunction

    task automatic send_cell(input cell_item_t it);
        start            <= 1'b1;
        command          <= it.command;
        time_difference  <= it.time_difference;
        rain_integrated  <= it.rain_integrated;
        wind_speed       <= it.wind_speed;
        flag_value_micro <= it.flag_value_micro;
        read_index       <= it.read_index;
        do
            @(posedge clk);
        while (busy);
        sb.note_cell(it);
        @(negedge clk);
    endtask

    // Start is low on entry, so it is only lowered for gaps inside the batch.
    task automatic send_batch(input cell_item_t batch [$]);
        int burst_left;
        int gap;
        bit steady;
        burst_left = 0;
        steady = ($urandom_range(0, 3) == 0);
        foreach (batch[i])
        begin
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = steady ? 0 : $urandom_range(0, 8);
                if (gap > 0)
                begin
                    if (i > 0)
                        start <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
            send_cell(batch[i]);
            burst_left--;
        end
        start <= 1'b0;
    endtask

    task automatic wait_idle();
        do
            @(negedge clk);
        while (sb.pending_outcomes.size() != 0 || busy);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        sb.write_reg(idx, data);
        @(negedge clk);
    endtask

    task automatic set_config(input logic [15:0] mm, input logic [15:0] thr,
                              input logic [15:0] marker, input bit spare);
        wait_idle();
        put_reg(CFG_MAX_MINUTES, mm);
        put_reg(CFG_RAIN_THRESH, thr);
        put_reg(CFG_MISSING_SPEED, marker);
        if (spare)
            put_reg(CFG_SPARE, 16'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase();
        cell_item_t batch [$];
        for (int n = 0; n < PHASE_ITEMS; n++)
            batch.push_back(random_cell());
        send_batch(batch);
    endtask

    initial
    begin
        cell_item_t directed [$];
        sb = new();
        rst_n            = 1'b0;
        start            = 1'b0;
        command          = CMD_SAMPLE;
        time_difference  = '0;
        rain_integrated  = '0;
        wind_speed       = '0;
        flag_value_micro = '0;
        read_index       = '0;
        cfg_we           = 1'b0;
        cfg_index        = CFG_MAX_MINUTES;
        cfg_data         = '0;
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Window edges, rain classes, flag edges and every read target under reset values.
        directed.push_back(make_item(CMD_READ,   0,    0,     0,        0, IDX_TOTAL));
        directed.push_back(make_item(CMD_SAMPLE, 75,   0,     0,        0, 0));
        directed.push_back(make_item(CMD_SAMPLE, 105,  21,    65535,    FLAG_FULL, 1023));
        directed.push_back(make_item(CMD_SAMPLE, 74,   5,     100,      500, 0));
        directed.push_back(make_item(CMD_SAMPLE, 106,  5,     100,      500, 0));
        directed.push_back(make_item(CMD_SAMPLE, 90,   20,    100,      1000, 0));
        directed.push_back(make_item(CMD_SAMPLE, 90,   1,     100,      1001, 0));
        directed.push_back(make_item(CMD_SAMPLE, 90,   999,   100,      99001, 0));
        directed.push_back(make_item(CMD_SAMPLE, 90,   1000,  100,      500, 0));
        directed.push_back(make_item(CMD_SAMPLE, 90,   65535, 100,      500, 0));
        directed.push_back(make_item(CMD_SAMPLE, 90,   5,     32767,    500, 0));
        directed.push_back(make_item(CMD_SAMPLE, 90,   5,     100,      -1, 0));
        directed.push_back(make_item(CMD_SAMPLE, 90,   30,    100,      -8388608, 0));
        directed.push_back(make_item(CMD_SAMPLE, 90,   0,     100,      8388607, 0));
        directed.push_back(make_item(CMD_SAMPLE, 90,   0,     100,      FLAG_FULL + 1, 0));
        directed.push_back(make_item(CMD_SAMPLE, 0,    5,     100,      500, 0));
        directed.push_back(make_item(CMD_SAMPLE, 255,  5,     100,      500, 0));
        directed.push_back(make_item(CMD_READ,   0,    0,     0,        0, IDX_TOTAL));
        directed.push_back(make_item(CMD_READ,   0,    0,     0,        0, IDX_CLASSIFIED));
        directed.push_back(make_item(CMD_READ,   0,    0,     0,        0, IDX_UNCLS0));
        directed.push_back(make_item(CMD_READ,   0,    0,     0,        0, IDX_UNCLS0 + 1));
        directed.push_back(make_item(CMD_READ,   0,    0,     0,        0, IDX_UNCLS0 + 2));
        directed.push_back(make_item(CMD_READ,   0,    0,     0,        0, 1));
        directed.push_back(make_item(CMD_READ,   0,    0,     0,        0, HIST_SIZE - 1));
        directed.push_back(make_item(CMD_READ,   0,    0,     0,        0, 1023));
        send_batch(directed);

        random_phase();
        set_config(16'd255, 16'd0, 16'd0, 1'b0);
        random_phase();
        // Upper data bits are junk for the 8-bit window register.
        set_config({8'($urandom), 8'd0}, 16'hFFFF, 16'hFFFF, 1'b1);
        random_phase();
        set_config(16'($urandom), 16'($urandom_range(0, 1100)), 16'($urandom), 1'b1);
        random_phase();

        wait_idle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (sb.error_count == 0 && sb.pending_outcomes.size() == 0)
            $display("[rain_flag_threshold_sweep_tally_core] OK");
        else
            $display("[rain_flag_threshold_sweep_tally_core] ERROR");
        $finish;
    end

endmodule
